// ===== rtl/qrm_pkg.sv =====
package qrm_pkg;
    localparam int IN_W          = 16;
    localparam int OUT_W         = 18;
    localparam int OUT_FRAC_BITS = 16;
    localparam int NUM_ENT       = 9;
    localparam int PROD_W        = 2 * IN_W;
    localparam int SUM_W         = 2 * IN_W + 1;
    localparam int NUM_W         = 2 * IN_W + 3;

    typedef logic signed [IN_W-1:0]  t_quat_c;
    typedef logic signed [OUT_W-1:0] t_ent;
endpackage

// ===== rtl/qrm_quat_if.sv =====
interface qrm_quat_if;
    import qrm_pkg::*;
    logic    valid;
    logic    ready;
    t_quat_c quat_w;
    t_quat_c quat_x;
    t_quat_c quat_y;
    t_quat_c quat_z;

    modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
    modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

// ===== rtl/qrm_mat_if.sv =====
interface qrm_mat_if;
    import qrm_pkg::*;
    logic valid;
    logic ready;
    t_ent m00;
    t_ent m01;
    t_ent m02;
    t_ent m10;
    t_ent m11;
    t_ent m12;
    t_ent m20;
    t_ent m21;
    t_ent m22;
    logic zero_norm;

    modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, zero_norm,
                    input ready);
    modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, zero_norm,
                    output ready);
endinterface

// ===== rtl/quaternion_to_rotation_matrix_top.sv =====
// Throughput: one item per cycle unless the output stalls; the nine restoring dividers
// resolve one quotient bit per pipeline stage, so the stage count follows OUT_FRAC_BITS.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
// Reset (synchronous, active low) clears the stage valid bits only.
module quaternion_to_rotation_matrix_top #(
    parameter int OUT_FRAC_BITS = qrm_pkg::OUT_FRAC_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    qrm_quat_if.sink  i_quat,
    qrm_mat_if.source o_mat
);
    import qrm_pkg::*;

    localparam int QW   = OUT_FRAC_BITS + 1;
    localparam int SW   = SUM_W;
    localparam int DW   = SW + QW;
    localparam int NDIV = QW;
    localparam int EW   = ((QW > OUT_W) ? QW : OUT_W) + 1;
    localparam logic signed [EW-1:0] OMAX =
        $signed({{(EW - OUT_W + 1){1'b0}}, {(OUT_W - 1){1'b1}}});
    localparam logic signed [EW-1:0] OMIN = ~OMAX;

    logic en;

    logic r_v_in, r_v_prod, r_v_sum, r_v_abs, r_v_out;
    logic [NDIV:0] r_v_div;

    t_quat_c r_w, r_x, r_y, r_z;
    logic signed [PROD_W-1:0] r_ww, r_xx, r_yy, r_zz, r_xy, r_zw, r_xz, r_yw, r_yz, r_xw;
    logic [SW-1:0]            r_s_sum, r_s_abs;
    logic signed [NUM_W-1:0]  r_num [NUM_ENT];
    logic [SW-1:0]            r_mag [NUM_ENT];
    logic [NUM_ENT-1:0]       r_neg_abs;
    logic                     r_zero_abs;

    logic [SW-1:0]      r_rem   [NDIV+1][NUM_ENT];
    logic [QW-1:0]      r_lq    [NDIV+1][NUM_ENT];
    logic [SW-1:0]      r_s_div [NDIV+1];
    logic [NUM_ENT-1:0] r_neg   [NDIV+1];
    logic               r_zero  [NDIV+1];

    logic [SW-1:0] n_rem [NDIV+1][NUM_ENT];
    logic [QW-1:0] n_lq  [NDIV+1][NUM_ENT];

    t_ent r_m [NUM_ENT];
    logic r_zn;
    t_ent n_m [NUM_ENT];

    logic signed [NUM_W-1:0] n_num [NUM_ENT];

    assign en           = !r_v_out || o_mat.ready;
    assign i_quat.ready = en;

    function automatic logic signed [NUM_W-1:0] ext(input logic signed [PROD_W-1:0] p);
        ext = NUM_W'(p);
    endfunction

    always_comb begin
        n_num[0] = ext(r_ww) + ext(r_xx) - ext(r_yy) - ext(r_zz);
        n_num[1] = (ext(r_xy) - ext(r_zw)) <<< 1;
        n_num[2] = (ext(r_xz) + ext(r_yw)) <<< 1;
        n_num[3] = (ext(r_xy) + ext(r_zw)) <<< 1;
        n_num[4] = ext(r_ww) - ext(r_xx) + ext(r_yy) - ext(r_zz);
        n_num[5] = (ext(r_yz) - ext(r_xw)) <<< 1;
        n_num[6] = (ext(r_xz) - ext(r_yw)) <<< 1;
        n_num[7] = (ext(r_yz) + ext(r_xw)) <<< 1;
        n_num[8] = ext(r_ww) - ext(r_xx) - ext(r_yy) + ext(r_zz);
    end

    always_comb begin
        logic [DW-1:0] d;
        logic [SW:0]   t;
        for (int e = 0; e < NUM_ENT; e++) begin
            d = (DW'(r_mag[e]) << OUT_FRAC_BITS) + DW'(r_s_abs >> 1);
            n_rem[0][e] = d[DW-1:QW];
            n_lq[0][e]  = d[QW-1:0];
        end
        for (int k = 1; k <= NDIV; k++) begin
            for (int e = 0; e < NUM_ENT; e++) begin
                t = {r_rem[k-1][e], r_lq[k-1][e][QW-1]};
                if (t >= {1'b0, r_s_div[k-1]}) begin
                    n_rem[k][e] = SW'(t - {1'b0, r_s_div[k-1]});
                    n_lq[k][e]  = {r_lq[k-1][e][QW-2:0], 1'b1};
                end else begin
                    n_rem[k][e] = t[SW-1:0];
                    n_lq[k][e]  = {r_lq[k-1][e][QW-2:0], 1'b0};
                end
            end
        end
    end

    always_comb begin
        logic signed [EW-1:0] qe, re;
        for (int e = 0; e < NUM_ENT; e++) begin
            qe = $signed({{(EW - QW){1'b0}}, r_lq[NDIV][e]});
            re = r_neg[NDIV][e] ? -qe : qe;
            if (r_zero[NDIV]) begin
                n_m[e] = '0;
            end else if (re > OMAX) begin
                n_m[e] = OMAX[OUT_W-1:0];
            end else if (re < OMIN) begin
                n_m[e] = OMIN[OUT_W-1:0];
            end else begin
                n_m[e] = re[OUT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_in   <= 1'b0;
            r_v_prod <= 1'b0;
            r_v_sum  <= 1'b0;
            r_v_abs  <= 1'b0;
            r_v_div  <= '0;
            r_v_out  <= 1'b0;
        end else if (en) begin
            r_v_in   <= i_quat.valid;
            r_v_prod <= r_v_in;
            r_v_sum  <= r_v_prod;
            r_v_abs  <= r_v_sum;
            r_v_div  <= {r_v_div[NDIV-1:0], r_v_abs};
            r_v_out  <= r_v_div[NDIV];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_w <= i_quat.quat_w;
            r_x <= i_quat.quat_x;
            r_y <= i_quat.quat_y;
            r_z <= i_quat.quat_z;

            r_ww <= r_w * r_w;
            r_xx <= r_x * r_x;
            r_yy <= r_y * r_y;
            r_zz <= r_z * r_z;
            r_xy <= r_x * r_y;
            r_zw <= r_z * r_w;
            r_xz <= r_x * r_z;
            r_yw <= r_y * r_w;
            r_yz <= r_y * r_z;
            r_xw <= r_x * r_w;

            r_s_sum <= SW'(r_ww[PROD_W-2:0]) + SW'(r_xx[PROD_W-2:0])
                     + SW'(r_yy[PROD_W-2:0]) + SW'(r_zz[PROD_W-2:0]);
            for (int e = 0; e < NUM_ENT; e++) begin
                r_num[e] <= n_num[e];
            end

            r_s_abs    <= r_s_sum;
            r_zero_abs <= (r_s_sum == '0);
            for (int e = 0; e < NUM_ENT; e++) begin
                r_neg_abs[e] <= r_num[e][NUM_W-1];
                r_mag[e]     <= r_num[e][NUM_W-1] ? SW'(-r_num[e]) : SW'(r_num[e]);
            end

            r_s_div[0] <= r_s_abs;
            r_neg[0]   <= r_neg_abs;
            r_zero[0]  <= r_zero_abs;
            for (int k = 1; k <= NDIV; k++) begin
                r_s_div[k] <= r_s_div[k-1];
                r_neg[k]   <= r_neg[k-1];
                r_zero[k]  <= r_zero[k-1];
            end
            for (int k = 0; k <= NDIV; k++) begin
                for (int e = 0; e < NUM_ENT; e++) begin
                    r_rem[k][e] <= n_rem[k][e];
                    r_lq[k][e]  <= n_lq[k][e];
                end
            end

            for (int e = 0; e < NUM_ENT; e++) begin
                r_m[e] <= n_m[e];
            end
            r_zn <= r_zero[NDIV];
        end
    end

    assign o_mat.valid     = r_v_out;
    assign o_mat.m00       = r_m[0];
    assign o_mat.m01       = r_m[1];
    assign o_mat.m02       = r_m[2];
    assign o_mat.m10       = r_m[3];
    assign o_mat.m11       = r_m[4];
    assign o_mat.m12       = r_m[5];
    assign o_mat.m20       = r_m[6];
    assign o_mat.m21       = r_m[7];
    assign o_mat.m22       = r_m[8];
    assign o_mat.zero_norm = r_zn;
endmodule

// ===== tb/sv/qrm_checker.sv =====
`timescale 1ns / 100ps

module qrm_checker (
    input  logic      i_clk,
    input  logic      i_rst_n,
    qrm_quat_if       quat,
    qrm_mat_if        mat,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_matrices_seen,
    output int        o_zero_seen
);
    import qrm_pkg::*;

    typedef struct packed {
        t_ent m00, m01, m02, m10, m11, m12, m20, m21, m22;
        logic zero_norm;
    } t_matrix;

    t_matrix expected_matrices[$];

    function automatic t_ent scale_ratio(longint num, longint s);
        longint mag;
        longint q;
        longint r;
        mag = (num < 0) ? -num : num;
        q = ((mag <<< OUT_FRAC_BITS) + (s >>> 1)) / s;
        r = (num < 0) ? -q : q;
        if (r > 131071) r = 131071;
        if (r < -131072) r = -131072;
        return t_ent'(r);
    endfunction

    function automatic t_matrix rotation_of(t_quat_c qw, t_quat_c qx, t_quat_c qy, t_quat_c qz);
        longint w, x, y, z, ww, xx, yy, zz, s;
        t_matrix m;
        w = qw; x = qx; y = qy; z = qz;
        ww = w * w; xx = x * x; yy = y * y; zz = z * z;
        s = ww + xx + yy + zz;
        m = '0;
        if (s == 0) begin
            m.zero_norm = 1'b1;
            return m;
        end
        m.m00 = scale_ratio(ww + xx - yy - zz, s);
        m.m01 = scale_ratio(2 * (x * y - z * w), s);
        m.m02 = scale_ratio(2 * (x * z + y * w), s);
        m.m10 = scale_ratio(2 * (x * y + z * w), s);
        m.m11 = scale_ratio(ww - xx + yy - zz, s);
        m.m12 = scale_ratio(2 * (y * z - x * w), s);
        m.m20 = scale_ratio(2 * (x * z - y * w), s);
        m.m21 = scale_ratio(2 * (y * z + x * w), s);
        m.m22 = scale_ratio(ww - xx - yy + zz, s);
        return m;
    endfunction

    task automatic compare_entry(string name, t_ent exp_v, t_ent act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            o_fail_count++;
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_matrices_seen = 0;
        o_zero_seen = 0;
    end

    assign o_pending = expected_matrices.size();

    always @(posedge i_clk) begin
        t_matrix exp_m;
        if (i_rst_n) begin
            if (quat.valid && quat.ready)
                expected_matrices.push_back(rotation_of(quat.quat_w, quat.quat_x,
                                                        quat.quat_y, quat.quat_z));
            if (mat.valid && mat.ready) begin
                o_matrices_seen++;
                if (mat.zero_norm) o_zero_seen++;
                if (expected_matrices.size() == 0) begin
                    $error("unexpected matrix item");
                    o_fail_count++;
                end else begin
                    exp_m = expected_matrices.pop_front();
                    compare_entry("m00", exp_m.m00, mat.m00);
                    compare_entry("m01", exp_m.m01, mat.m01);
                    compare_entry("m02", exp_m.m02, mat.m02);
                    compare_entry("m10", exp_m.m10, mat.m10);
                    compare_entry("m11", exp_m.m11, mat.m11);
                    compare_entry("m12", exp_m.m12, mat.m12);
                    compare_entry("m20", exp_m.m20, mat.m20);
                    compare_entry("m21", exp_m.m21, mat.m21);
                    compare_entry("m22", exp_m.m22, mat.m22);
                    if (exp_m.zero_norm !== mat.zero_norm) begin
                        $error("zero_norm mismatch: expected %0b, got %0b",
                               exp_m.zero_norm, mat.zero_norm);
                        o_fail_count++;
                    end
                end
            end
        end
    end
endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import qrm_pkg::*;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   matrices_seen;
    int   zero_seen;
    int   hold_off;
    logic no_idle;

    qrm_quat_if quat_ch ();
    qrm_mat_if  mat_ch ();

    quaternion_to_rotation_matrix_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_quat  (quat_ch.sink),
        .o_mat   (mat_ch.source)
    );

    qrm_checker rot_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .quat            (quat_ch),
        .mat             (mat_ch),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_matrices_seen (matrices_seen),
        .o_zero_seen     (zero_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("status: fail");
        $finish;
    end

    // receiver: random stalls, one long hold-off, a calm stretch
    initial begin
        mat_ch.ready = 1'b0;
        hold_off = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off > 0) begin
                mat_ch.ready = 1'b0;
                hold_off--;
            end else begin
                mat_ch.ready = no_idle || ($urandom_range(99) >= 28);
            end
        end
    end

    task automatic send_quat(t_quat_c w, t_quat_c x, t_quat_c y, t_quat_c z);
        while (!no_idle && $urandom_range(99) < 28) begin
            quat_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        quat_ch.valid  = 1'b1;
        quat_ch.quat_w = w;
        quat_ch.quat_x = x;
        quat_ch.quat_y = y;
        quat_ch.quat_z = z;
        @(posedge i_clk);
        while (!quat_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        quat_ch.valid = 1'b0;
    endtask

    function automatic t_quat_c rand_comp();
        case ($urandom_range(5))
            0: return t_quat_c'($urandom);
            1: return t_quat_c'($urandom_range(32767));
            2: return -t_quat_c'($urandom_range(32767));
            3: return t_quat_c'($signed($urandom_range(64)) - 32);
            4: return ($urandom_range(1)) ? 16'sh7fff : 16'sh8000;
            default: return t_quat_c'($signed($urandom_range(32768)) - 16384);
        endcase
    endfunction

    initial begin
        quat_ch.valid  = 1'b0;
        quat_ch.quat_w = '0;
        quat_ch.quat_x = '0;
        quat_ch.quat_y = '0;
        quat_ch.quat_z = '0;
        no_idle = 1'b0;
        i_rst_n = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_quat(0, 0, 0, 0);
        send_quat(16384, 0, 0, 0);
        send_quat(0, 16384, 0, 0);
        send_quat(0, 0, 16384, 0);
        send_quat(0, 0, 0, 16384);
        send_quat(-32768, 0, 0, 0);
        send_quat(32767, 0, 0, 0);
        send_quat(0, -32768, 0, 0);
        send_quat(-32768, -32768, -32768, -32768);
        send_quat(32767, 32767, 32767, 32767);
        send_quat(32767, -32768, 32767, -32768);
        send_quat(1, 0, 0, 0);
        send_quat(0, 0, 0, -1);
        send_quat(1, 1, 0, 0);
        send_quat(1, 1, 1, 0);
        send_quat(3, 0, 0, 0);
        send_quat(11585, 11585, 0, 0);
        send_quat(0, 0, 0, 0);
        send_quat(-16384, 0, 16384, 0);
        send_quat(8192, -8192, 8192, -8192);

        // fill the pipeline against a stalled output
        hold_off = 150;
        no_idle = 1'b1;
        repeat (60) send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
        no_idle = 1'b0;

        for (int n = 0; n < 840; n++) begin
            no_idle = (n >= 300 && n < 420);
            if ($urandom_range(49) == 0)
                send_quat(0, 0, 0, 0);
            else
                send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
        end
        no_idle = 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (2 * OUT_FRAC_BITS + 20) @(posedge i_clk);

        $display("covered %0d matrices, %0d from a zero quaternion, with stalls on both sides",
                 matrices_seen, zero_seen);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
